@@ sv/pcrs_pkg.sv @@
// Package with shared types and constants for the pulse counter and recharge scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pcrs_pkg;

	// Action codes carried by an input transaction.
	typedef enum logic [2:0] {
		ACT_PULSE_A   = 3'd0,
		ACT_PULSE_B   = 3'd1,
		ACT_TICK      = 3'd2,
		ACT_READ_CNT  = 3'd3,
		ACT_READ_TOT  = 3'd4,
		ACT_POLL      = 3'd5,
		ACT_REFUSED   = 3'd6,
		ACT_NONE      = 3'd7
	} pcrs_action_t;

	// Configuration register indexes (byte address divided by four).
	typedef enum logic [1:0] {
		REG_PULSE_THR   = 2'd0,
		REG_SECONDS_THR = 2'd1,
		REG_SECONDS_REF = 2'd2,
		REG_UNUSED      = 2'd3
	} pcrs_reg_t;

	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned SHORT_W = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [SHORT_W-1:0] PULSE_THR_RST   = 16'd20;
	localparam logic [SHORT_W-1:0] SECONDS_THR_RST = 16'd20;
	localparam logic [SHORT_W-1:0] SECONDS_REF_RST = 16'd15;
	localparam logic [SHORT_W-1:0] SECONDS_RST     = SECONDS_THR_RST - 16'd1;

	// One result transaction.
	typedef struct packed {
		logic [COUNT_W-1:0] count_a;
		logic [COUNT_W-1:0] count_b;
		logic               recharge_request;
		logic               recharge_alert_mode;
		logic               keep_running_request;
	} pcrs_result_t;

endpackage
`default_nettype wire

@@ sv/pcrs_if.sv @@
// Valid/ready channel interfaces for the input events and the results.
`timescale 1ns / 1ps
`default_nettype none
interface pcrs_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic       clear_after_read;
	logic       alert;
	logic       gen_running;
	logic       refused;

	modport source (output valid, action, clear_after_read, alert, gen_running, refused,
		input ready);
	modport sink (input valid, action, clear_after_read, alert, gen_running, refused,
		output ready);
endinterface

interface pcrs_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] count_a;
	logic [31:0] count_b;
	logic        recharge_request;
	logic        recharge_alert_mode;
	logic        keep_running_request;

	modport source (output valid, count_a, count_b, recharge_request, recharge_alert_mode,
		keep_running_request, input ready);
	modport sink (input valid, count_a, count_b, recharge_request, recharge_alert_mode,
		keep_running_request, output ready);
endinterface
`default_nettype wire

@@ sv/pulse_counter_recharge_scheduler.sv @@
// Top level of the two-tube pulse counter and recharge scheduler.
//
// Usage:
// Events arrive on the item channel (valid/ready): pulses on tube a or b, second
// ticks, count and total reads, polls and recharge refusals. Every accepted
// transaction gives exactly one result transaction on the result channel.
// The counters and recharge state update at the edge that accepts the event,
// and the result sits in the output register from the next cycle on. One event
// is taken every cycle while the result channel drains; the output register is
// the only buffer, so a stalled result holds the item channel ready low until it
// is taken. Thresholds are written over the APB port (byte addresses 0, 4 and 8);
// the user must write them only while the block is idle, which the block itself
// does not enforce. pready is always high and reads return the register.
// Reset clears the tube counters and totals and the recharge pulse count,
// loads the seconds count with one less than the default seconds threshold,
// restores the register defaults and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module pulse_counter_recharge_scheduler (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [pcrs_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pcrs_pkg::DATA_W-1:0] pwdata,
	output logic      [pcrs_pkg::DATA_W-1:0] prdata,
	output logic                           pready,
	pcrs_item_if.sink                      item,
	pcrs_result_if.source                  result
);
	import pcrs_pkg::*;

	logic [SHORT_W-1:0] pulse_thr_q;
	logic [SHORT_W-1:0] seconds_thr_q;
	logic [SHORT_W-1:0] seconds_ref_q;

	logic [COUNT_W-1:0] tube_a_count_q;
	logic [COUNT_W-1:0] tube_b_count_q;
	logic [COUNT_W-1:0] tube_a_total_q;
	logic [COUNT_W-1:0] tube_b_total_q;
	logic [SHORT_W-1:0] pulses_q;
	logic [SHORT_W-1:0] seconds_q;

	logic [COUNT_W-1:0] tube_a_count_d;
	logic [COUNT_W-1:0] tube_b_count_d;
	logic [COUNT_W-1:0] tube_a_total_d;
	logic [COUNT_W-1:0] tube_b_total_d;
	logic [SHORT_W-1:0] pulses_d;
	logic [SHORT_W-1:0] seconds_d;

	pcrs_result_t res_d;
	pcrs_result_t res_q;
	logic         res_valid_q;
	logic         accept;
	logic         cfg_write;
	pcrs_reg_t    reg_idx;
	pcrs_action_t action;
	logic         pulse_bump;
	logic         due;

	// Configuration port decode.
	assign pready    = 1'b1;
	assign reg_idx   = pcrs_reg_t'(paddr[ADDR_W-1:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_thr_q   <= PULSE_THR_RST;
			seconds_thr_q <= SECONDS_THR_RST;
			seconds_ref_q <= SECONDS_REF_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_PULSE_THR:   pulse_thr_q   <= pwdata[SHORT_W-1:0];
				REG_SECONDS_THR: seconds_thr_q <= pwdata[SHORT_W-1:0];
				REG_SECONDS_REF: seconds_ref_q <= pwdata[SHORT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_PULSE_THR:   prdata = {{(DATA_W-SHORT_W){1'b0}}, pulse_thr_q};
			REG_SECONDS_THR: prdata = {{(DATA_W-SHORT_W){1'b0}}, seconds_thr_q};
			REG_SECONDS_REF: prdata = {{(DATA_W-SHORT_W){1'b0}}, seconds_ref_q};
			default:         prdata = '0;
		endcase
	end

	// Handshake: a new event is taken whenever the output register is free or drains.
	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;
	assign action     = pcrs_action_t'(item.action);

	// The recharge pulse count stops at the threshold.
	assign pulse_bump = (pulses_q < pulse_thr_q);
	assign due        = (pulses_q >= pulse_thr_q) || (seconds_q >= seconds_thr_q);

	// Next state and result for the event at the item port.
	always_comb begin
		tube_a_count_d = tube_a_count_q;
		tube_b_count_d = tube_b_count_q;
		tube_a_total_d = tube_a_total_q;
		tube_b_total_d = tube_b_total_q;
		pulses_d       = pulses_q;
		seconds_d      = seconds_q;
		res_d          = '0;
		unique case (action)
			ACT_PULSE_A: begin
				if (tube_a_count_q != COUNT_MAX) tube_a_count_d = tube_a_count_q + 1'b1;
				tube_a_total_d = tube_a_total_q + 1'b1;
				if (pulse_bump) pulses_d = pulses_q + 1'b1;
			end
			ACT_PULSE_B: begin
				if (tube_b_count_q != COUNT_MAX) tube_b_count_d = tube_b_count_q + 1'b1;
				tube_b_total_d = tube_b_total_q + 1'b1;
				if (pulse_bump) pulses_d = pulses_q + 1'b1;
			end
			ACT_TICK: begin
				seconds_d = seconds_q + 1'b1;
			end
			ACT_READ_CNT: begin
				res_d.count_a = tube_a_count_q;
				res_d.count_b = tube_b_count_q;
				if (item.clear_after_read) begin
					tube_a_count_d = '0;
					tube_b_count_d = '0;
				end
			end
			ACT_READ_TOT: begin
				res_d.count_a = tube_a_total_q;
				res_d.count_b = tube_b_total_q;
				if (item.clear_after_read) begin
					tube_a_total_d = '0;
					tube_b_total_d = '0;
				end
			end
			ACT_POLL: begin
				if (item.refused) begin
					seconds_d = seconds_ref_q;
				end else begin
					if (due) begin
						pulses_d  = '0;
						seconds_d = '0;
					end
					res_d.recharge_request     = due || item.alert;
					res_d.recharge_alert_mode  = item.alert;
					res_d.keep_running_request = !item.alert && item.gen_running;
				end
			end
			ACT_REFUSED: begin
				seconds_d = seconds_ref_q;
			end
			default: ;
		endcase
	end

	// Counter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tube_a_count_q <= '0;
			tube_b_count_q <= '0;
			tube_a_total_q <= '0;
			tube_b_total_q <= '0;
			pulses_q       <= '0;
			seconds_q      <= SECONDS_RST;
		end else if (accept) begin
			tube_a_count_q <= tube_a_count_d;
			tube_b_count_q <= tube_b_count_d;
			tube_a_total_q <= tube_a_total_d;
			tube_b_total_q <= tube_b_total_d;
			pulses_q       <= pulses_d;
			seconds_q      <= seconds_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign result.valid                = res_valid_q;
	assign result.count_a              = res_q.count_a;
	assign result.count_b              = res_q.count_b;
	assign result.recharge_request     = res_q.recharge_request;
	assign result.recharge_alert_mode  = res_q.recharge_alert_mode;
	assign result.keep_running_request = res_q.keep_running_request;

endmodule
`default_nettype wire

@@ sv/pcrs_checker.sv @@
// Port-level checker for the pulse counter and recharge scheduler, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module pcrs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] count_a,
	input wire logic        recharge_request,
	input wire logic        recharge_alert_mode,
	input wire logic        keep_running_request
);

	// A stalled result must not let a new transaction in.
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !item_ready)
		else $error("item accepted while result stalled");

	// Every accepted transaction shows a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> res_valid)
		else $error("accepted transaction gave no result");

	// Alert mode only ever comes with a recharge request, never with keep-running.
	a_alert_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && recharge_alert_mode |-> recharge_request && !keep_running_request)
		else $error("alert mode flag inconsistent");

	// A stalled result holds its payload.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(count_a) && $stable(recharge_request))
		else $error("stalled result changed");

endmodule

bind pulse_counter_recharge_scheduler pcrs_checker u_pcrs_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.item_valid          (item.valid),
	.item_ready          (item.ready),
	.res_valid           (result.valid),
	.res_ready           (result.ready),
	.count_a             (result.count_a),
	.recharge_request    (result.recharge_request),
	.recharge_alert_mode (result.recharge_alert_mode),
	.keep_running_request(result.keep_running_request)
);
`default_nettype wire
